>>> design/gcm_pkg.sv
// Shared types, codes and constants of the greedy change maker.
`timescale 1ns / 1ps

package gcm_pkg;

  // Width of amounts, denominations, quantities and remainders.
  localparam int unsigned AMT_W = 15;
  // Width of the target amount on the input stream.
  localparam int unsigned TARGET_W = 16;
  // Width of a denomination position and of the denomination count.
  localparam int unsigned IDX_W = 3;
  // Output tdata width: index, quantity and remainder rounded up to bytes.
  localparam int unsigned OUT_TDATA_W = 40;
  // Divider steps, one quotient bit per step.
  localparam int unsigned DIV_STEPS = AMT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_IDX_COUNT  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_DENOM0 = 3'd1;

  // Register values after reset.
  localparam logic [IDX_W-1:0] COUNT_RESET = 3'd5;
  localparam logic [5:0][AMT_W-1:0] DENOM_RESET = {
    15'd0, 15'd1, 15'd2, 15'd5, 15'd10, 15'd50
  };

  // Status carried on the last result of a target.
  typedef enum logic [1:0] {
    ST_SUCCESS      = 2'd0,
    ST_GREEDY_FAIL  = 2'd1,
    ST_NOT_POSITIVE = 2'd2
  } change_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POS,
    S_DIV,
    S_EMIT
  } gcm_state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [AMT_W-1:0] dividend;
    logic [AMT_W-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [AMT_W-1:0] quotient;
    logic [AMT_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/greedy_change_maker.sv
// Top level of the greedy change maker: sequencer, output register, checks.
`timescale 1ns / 1ps

// Greedy change maker.
// Input stream (s_axis_*): one beat carries a target amount, two's complement.
// Output stream (m_axis_*): one beat per denomination position in use, in
// position order; tlast marks the final beat, which also carries the unpaid
// remainder and the status (success, greedy failure, target not positive).
// Configuration (cfg_*): index 0 is the denomination count, index 1 to 6 the
// denomination values, largest first. Writes are taken every cycle and are
// meant to be issued only while the block is idle.
// Sequence: a beat is taken in the idle state. Each position is then decided
// in S_POS, divided in S_DIV by the shared 15-step divider when it needs a
// division, and loaded into the output register in S_EMIT; a skipped one goes
// straight to S_EMIT. s_axis_tready is low while a target is in work. A
// stalled receiver holds the output register and the sequencer waits at the
// next load; the next target may be taken while the final beat waits.
// Reset puts the denominations back to 50, 10, 5, 2, 1, 0 with count 5 and
// drops any beat in flight.
module greedy_change_maker #(
  parameter int unsigned MAX_DENOMS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] target
  input  logic [gcm_pkg::TARGET_W-1:0]        s_axis_tdata,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] denom_index, [17:3] coin_quantity, [32:18] unpaid rest,
  // [39:33] zero
  output logic [gcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [1:0] change_status
  output logic [1:0]                          m_axis_tuser,
  // last_result
  output logic                                m_axis_tlast,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gcm_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [gcm_pkg::AMT_W-1:0]           cfg_data_i
);

  localparam int unsigned SelW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int unsigned PadW = gcm_pkg::OUT_TDATA_W - gcm_pkg::IDX_W - 2 * gcm_pkg::AMT_W;

  logic [gcm_pkg::IDX_W-1:0]                 count_eff;
  logic [MAX_DENOMS-1:0][gcm_pkg::AMT_W-1:0] denoms;

  gcm_pkg::gcm_state_e        state_q, state_d;
  logic [gcm_pkg::IDX_W-1:0]  k_q, k_d;
  logic [gcm_pkg::IDX_W-1:0]  n_q, n_d;
  logic [gcm_pkg::AMT_W-1:0]  rem_q, rem_d;
  logic [gcm_pkg::AMT_W-1:0]  qty_q, qty_d;
  logic                       run_q, run_d;
  logic                       pos_q, pos_d;

  logic                       out_valid_q, out_valid_d;
  logic [gcm_pkg::IDX_W-1:0]  out_index_q, out_index_d;
  logic [gcm_pkg::AMT_W-1:0]  out_qty_q, out_qty_d;
  logic [gcm_pkg::AMT_W-1:0]  out_rem_q, out_rem_d;
  gcm_pkg::change_status_e    out_status_q, out_status_d;
  logic                       out_last_q, out_last_d;

  gcm_pkg::div_req_t          div_req;
  gcm_pkg::div_rsp_t          div_rsp;

  logic                       in_beat;
  logic                       target_pos;
  logic [gcm_pkg::AMT_W-1:0]  cur_denom;
  logic                       go_div;
  logic                       out_free;
  logic                       is_last;
  gcm_pkg::change_status_e    final_status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  gcm_cfg_regs #(
    .MAX_DENOMS (MAX_DENOMS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .count_o    (count_eff),
    .denoms_o   (denoms)
  );

  // Shared divider.
  gcm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Common conditions.
  assign s_axis_tready = (state_q == gcm_pkg::S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign target_pos    = (s_axis_tdata != '0) && !s_axis_tdata[gcm_pkg::TARGET_W-1];
  assign cur_denom     = denoms[k_q[SelW-1:0]];
  assign go_div        = run_q && (rem_q != '0) && (cur_denom != '0);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_last       = (k_q == n_q - gcm_pkg::IDX_W'(1));
  assign final_status  = !pos_q ? gcm_pkg::ST_NOT_POSITIVE :
                         (rem_q == '0) ? gcm_pkg::ST_SUCCESS : gcm_pkg::ST_GREEDY_FAIL;

  assign div_req.start    = (state_q == gcm_pkg::S_POS) && go_div;
  assign div_req.dividend = rem_q;
  assign div_req.divisor  = cur_denom;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcm_pkg::S_IDLE: begin
        if (in_beat) state_d = gcm_pkg::S_POS;
      end
      gcm_pkg::S_POS: begin
        state_d = go_div ? gcm_pkg::S_DIV : gcm_pkg::S_EMIT;
      end
      gcm_pkg::S_DIV: begin
        if (div_rsp.done) state_d = gcm_pkg::S_EMIT;
      end
      gcm_pkg::S_EMIT: begin
        if (out_free) state_d = is_last ? gcm_pkg::S_IDLE : gcm_pkg::S_POS;
      end
      default: state_d = gcm_pkg::S_IDLE;
    endcase
  end

  // Working registers and output register loads.
  always_comb begin
    k_d          = k_q;
    n_d          = n_q;
    rem_d        = rem_q;
    qty_d        = qty_q;
    run_d        = run_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_index_d  = out_index_q;
    out_qty_d    = out_qty_q;
    out_rem_d    = out_rem_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    case (state_q)
      gcm_pkg::S_IDLE: begin
        if (in_beat) begin
          k_d   = '0;
          n_d   = count_eff;
          pos_d = target_pos;
          run_d = target_pos;
          rem_d = target_pos ? s_axis_tdata[gcm_pkg::AMT_W-1:0] : '0;
        end
      end
      gcm_pkg::S_POS: begin
        if (!go_div) begin
          run_d = 1'b0;
          qty_d = '0;
        end
      end
      gcm_pkg::S_DIV: begin
        if (div_rsp.done) begin
          qty_d = div_rsp.quotient;
          rem_d = div_rsp.remainder;
        end
      end
      gcm_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_index_d  = k_q;
          out_qty_d    = qty_q;
          out_last_d   = is_last;
          out_rem_d    = is_last ? rem_q : '0;
          out_status_d = is_last ? final_status : gcm_pkg::ST_SUCCESS;
          k_d          = k_q + gcm_pkg::IDX_W'(1);
        end
      end
      default: begin
        run_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcm_pkg::S_IDLE;
      k_q         <= '0;
      n_q         <= gcm_pkg::IDX_W'(1);
      run_q       <= 1'b0;
      pos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      n_q         <= n_d;
      run_q       <= run_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    qty_q        <= qty_d;
    out_index_q  <= out_index_d;
    out_qty_q    <= out_qty_d;
    out_rem_q    <= out_rem_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  // Output stream.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_rem_q, out_qty_q, out_index_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // The divider is never in use while a new target can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_rsp.busy)
    else $error("divider busy while input is ready");

  // A division result only arrives while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == gcm_pkg::S_DIV))
    else $error("divider result outside the divide state");

  // A division is never started with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (div_req.divisor != '0))
    else $error("division started by zero");

  // The position in work stays below the count while a target is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != gcm_pkg::S_IDLE) |-> (k_q < n_q))
    else $error("position past the denomination count");
`endif

endmodule

>>> design/gcm_cfg_regs.sv
// Configuration registers: denomination count and denomination values.
`timescale 1ns / 1ps

module gcm_cfg_regs #(
  parameter int unsigned MAX_DENOMS = 6
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         wr_en_i,
  input  logic [gcm_pkg::IDX_W-1:0]                    wr_index_i,
  input  logic [gcm_pkg::AMT_W-1:0]                    wr_data_i,
  output logic [gcm_pkg::IDX_W-1:0]                    count_o,
  output logic [MAX_DENOMS-1:0][gcm_pkg::AMT_W-1:0]    denoms_o
);

  localparam logic [gcm_pkg::IDX_W-1:0] MaxCount = gcm_pkg::IDX_W'(MAX_DENOMS);

  logic [gcm_pkg::IDX_W-1:0]                 count_q;
  logic [MAX_DENOMS-1:0][gcm_pkg::AMT_W-1:0] denom_q;

  // Count register, written with its low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= gcm_pkg::COUNT_RESET;
    end else if (wr_en_i && (wr_index_i == gcm_pkg::CFG_IDX_COUNT)) begin
      count_q <= wr_data_i[gcm_pkg::IDX_W-1:0];
    end
  end

  // One register per denomination position; writes to positions past the
  // last one held here are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DENOMS; i++) begin
        denom_q[i] <= gcm_pkg::DENOM_RESET[i];
      end
    end else if (wr_en_i) begin
      for (int i = 0; i < MAX_DENOMS; i++) begin
        if (wr_index_i == gcm_pkg::CFG_IDX_DENOM0 + gcm_pkg::IDX_W'(i)) begin
          denom_q[i] <= wr_data_i;
        end
      end
    end
  end

  assign denoms_o = denom_q;

  // A count of zero acts as one, a count above the depth as the depth.
  always_comb begin
    if (count_q == '0) begin
      count_o = gcm_pkg::IDX_W'(1);
    end else if (count_q > MaxCount) begin
      count_o = MaxCount;
    end else begin
      count_o = count_q;
    end
  end

endmodule

>>> design/gcm_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gcm_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcm_pkg::div_req_t req_i,
  output gcm_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [gcm_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [gcm_pkg::AMT_W-1:0]       acc_q, acc_d;
  logic [gcm_pkg::AMT_W-1:0]       quo_q, quo_d;
  logic [gcm_pkg::AMT_W-1:0]       dvs_q, dvs_d;
  logic [gcm_pkg::AMT_W:0]         shifted;
  logic [gcm_pkg::AMT_W+1:0]       diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {acc_q, quo_q[gcm_pkg::AMT_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  // Step control and datapath.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = gcm_pkg::DIV_CNT_W'(gcm_pkg::DIV_STEPS);
      acc_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[gcm_pkg::AMT_W+1]) begin
        acc_d = diff[gcm_pkg::AMT_W-1:0];
        quo_d = {quo_q[gcm_pkg::AMT_W-2:0], 1'b1};
      end else begin
        acc_d = shifted[gcm_pkg::AMT_W-1:0];
        quo_d = {quo_q[gcm_pkg::AMT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - gcm_pkg::DIV_CNT_W'(1);
      if (cnt_q == gcm_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = acc_q;

endmodule
